[rtl/core/dlu_pkg.sv]
// ============================================================================
// dlu_pkg
// Shared types, widths and codes for the dense LU linear solver.
// ============================================================================
package dlu_pkg;

    localparam int WORD_W        = 48;
    localparam int VAL_W         = 32;
    localparam int IDX_W         = 4;
    localparam int ORD_W         = 5;
    localparam int MAX_ORDER_DEF = 16;
    localparam int FRAC_BITS_DEF = 16;

    localparam logic [ORD_W-1:0] ORD_RESET = ORD_W'(16);

    localparam logic KIND_MAT = 1'b0;
    localparam logic KIND_VEC = 1'b1;

    localparam logic [1:0] WSEL_ZERO = 2'd0;
    localparam logic [1:0] WSEL_LOAD = 2'd1;
    localparam logic [1:0] WSEL_S    = 2'd2;

    typedef struct packed {
        logic                    kind;
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
        logic                    last_item;
    } t_item;

    typedef struct packed {
        logic [IDX_W-1:0]        index;
        logic signed [VAL_W-1:0] solution;
        logic                    singular;
        logic                    saturated;
        logic                    last_result;
    } t_result;

    typedef struct packed {
        logic             ld_s;
        logic             ld_a;
        logic             mul_start;
        logic             div_start;
        logic             sel_vec;
        logic [1:0]       wsel;
        logic             chk32;
        logic             emit;
        logic [IDX_W-1:0] emit_idx;
        logic             emit_last;
        logic             clr_flags;
    } t_cmd;

    typedef struct packed {
        logic mul_busy;
        logic div_busy;
    } t_sts;

endpackage

[rtl/core/dense_lu_linear_solver_unit.sv]
// ============================================================================
// dense_lu_linear_solver_unit
// Dense linear solver: Doolittle LU without pivoting, then forward and back
// substitution, signed fixed point.
// ============================================================================
// Usage:
// Load items are offered on i_item with start. One is taken at each clock edge
// where start is high and busy is low, so loading runs at one beat per cycle.
// Matrix elements and right-hand-side entries that are never loaded are zero.
// An item with last_item set is stored and then starts the solve; busy stays
// high until the stores have been cleared again.
// The solve runs on a single shared multiplier and a restoring divider. A
// system of order n takes about n^3/3 + n^2 product steps and n^2/2 + n/2
// quotient steps.
// The solution entries then come out in index order, each on o_result for
// exactly one cycle with o_strobe high; the receiver must take them as they
// come.
// After the last entry, and after reset, a clearing sweep over all
// MAX_ORDER*MAX_ORDER matrix addresses zeroes the stores while busy is high.
// The order register (i_cfg_we, i_cfg_wdata) resets to 16; it is to be written
// only while the block is idle, which the block itself does not enforce.
// ============================================================================
module dense_lu_linear_solver_unit #(
    parameter int MAX_ORDER = dlu_pkg::MAX_ORDER_DEF,
    parameter int FRAC_BITS = dlu_pkg::FRAC_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  dlu_pkg::t_item            i_item,
    input  logic                      i_cfg_we,
    input  logic [dlu_pkg::ORD_W-1:0] i_cfg_wdata,
    output logic                      o_strobe,
    output dlu_pkg::t_result          o_result
);
    import dlu_pkg::*;

    localparam int MD  = MAX_ORDER * MAX_ORDER;
    localparam int MAW = $clog2(MD);
    localparam int VAW = $clog2(MAX_ORDER);

    t_cmd              cmd;
    t_sts              sts;
    logic              mat_we, vec_we;
    logic [MAW-1:0]    mat_waddr, mat_raddr;
    logic [VAW-1:0]    vec_waddr, vec_raddr;
    logic [WORD_W-1:0] mat_rdata, vec_rdata, wdata;

    dlu_ctrl #(
        .MAX_ORDER (MAX_ORDER)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cmd       (cmd),
        .i_sts       (sts),
        .o_mat_we    (mat_we),
        .o_mat_waddr (mat_waddr),
        .o_mat_raddr (mat_raddr),
        .o_vec_we    (vec_we),
        .o_vec_waddr (vec_waddr),
        .o_vec_raddr (vec_raddr)
    );

    dlu_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_mat_rdata (mat_rdata),
        .i_vec_rdata (vec_rdata),
        .i_value     (i_item.value),
        .o_wdata     (wdata),
        .o_strobe    (o_strobe),
        .o_result    (o_result)
    );

    dlu_ram #(
        .W (WORD_W),
        .D (MD)
    ) u_mat_ram (
        .i_clk   (i_clk),
        .i_we    (mat_we),
        .i_waddr (mat_waddr),
        .i_wdata (wdata),
        .i_raddr (mat_raddr),
        .o_rdata (mat_rdata)
    );

    dlu_ram #(
        .W (WORD_W),
        .D (MAX_ORDER)
    ) u_vec_ram (
        .i_clk   (i_clk),
        .i_we    (vec_we),
        .i_waddr (vec_waddr),
        .i_wdata (wdata),
        .i_raddr (vec_raddr),
        .o_rdata (vec_rdata)
    );
endmodule

[rtl/core/dlu_ram.sv]
// ============================================================================
// dlu_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
module dlu_ram #(
    parameter int W = 48,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/core/dlu_datapath.sv]
// ============================================================================
// dlu_datapath
// Accumulator, sequential multiplier, restoring divider, flags and result
// register of the LU solver.
// ============================================================================
module dlu_datapath #(
    parameter int FRAC_BITS = dlu_pkg::FRAC_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dlu_pkg::t_cmd                  i_cmd,
    output dlu_pkg::t_sts                  o_sts,
    input  logic [dlu_pkg::WORD_W-1:0]     i_mat_rdata,
    input  logic [dlu_pkg::WORD_W-1:0]     i_vec_rdata,
    input  logic signed [dlu_pkg::VAL_W-1:0] i_value,
    output logic [dlu_pkg::WORD_W-1:0]     o_wdata,
    output logic                           o_strobe,
    output dlu_pkg::t_result               o_result
);
    import dlu_pkg::*;

    localparam int NW  = WORD_W + FRAC_BITS;
    localparam int DCW = $clog2(NW + 1);
    localparam int PW  = 2 * WORD_W;
    localparam int HW  = WORD_W / 2;

    localparam logic [WORD_W-1:0] W_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] W_MIN = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic [WORD_W-1:0] W_MAG = {1'b1, {(WORD_W-1){1'b0}}};
    localparam logic [NW-1:0]     Q_MAG = NW'(W_MAG);

    localparam logic [2:0] MS_IDLE = 3'd0;
    localparam logic [2:0] MS_P0   = 3'd1;
    localparam logic [2:0] MS_P1   = 3'd2;
    localparam logic [2:0] MS_P2   = 3'd3;
    localparam logic [2:0] MS_P3   = 3'd4;
    localparam logic [2:0] MS_FIN  = 3'd5;

    function automatic logic [WORD_W-1:0] mag(input logic [WORD_W-1:0] a);
        logic [WORD_W-1:0] m;
        m = a[WORD_W-1] ? (~a + 1'b1) : a;
        return m;
    endfunction

    logic [WORD_W-1:0] r_s, r_a, r_ma, r_mb, r_rem, r_md;
    logic              r_mneg, r_dneg;
    logic [PW-1:0]     r_prod;
    logic [2:0]        r_mstep;
    logic [NW-1:0]     r_dnum, r_q;
    logic [DCW-1:0]    r_dcnt;
    logic              r_dbusy;
    logic              r_sing, r_sat;
    logic              r_strobe;
    t_result           r_res;

    logic [WORD_W-1:0] rd_sel;
    logic [HW-1:0]     op_x, op_y;
    logic [WORD_W-1:0] pp;
    logic [PW-1:0]     pp_sh;
    logic              p_ovf;
    logic [WORD_W-1:0] p_m, p_val;
    logic              mul_sat;
    logic [WORD_W:0]   diff;
    logic [WORD_W-1:0] mul_res;
    logic [WORD_W-1:0] md_new;
    logic              md_zero;
    logic [WORD_W:0]   rem2;
    logic              rem_ge;
    logic              div_fin;
    logic [WORD_W-1:0] div_res;
    logic              div_sat;
    logic              s_out32;
    logic              v_out32;
    logic [VAL_W-1:0]  v_clamp;
    logic              sing_set, sat_set;

    assign rd_sel = i_cmd.sel_vec ? i_vec_rdata : i_mat_rdata;

    // One 24x24 partial product per cycle.
    always_comb begin
        op_x  = r_ma[HW-1:0];
        op_y  = r_mb[HW-1:0];
        pp_sh = '0;
        case (r_mstep)
            MS_P0: begin
                op_x = r_ma[HW-1:0];
                op_y = r_mb[HW-1:0];
            end
            MS_P1: begin
                op_x = r_ma[WORD_W-1:HW];
                op_y = r_mb[HW-1:0];
            end
            MS_P2: begin
                op_x = r_ma[HW-1:0];
                op_y = r_mb[WORD_W-1:HW];
            end
            MS_P3: begin
                op_x = r_ma[WORD_W-1:HW];
                op_y = r_mb[WORD_W-1:HW];
            end
            default: begin
                op_x = r_ma[HW-1:0];
                op_y = r_mb[HW-1:0];
            end
        endcase
        pp = WORD_W'(op_x) * WORD_W'(op_y);
        case (r_mstep)
            MS_P0:   pp_sh = PW'(pp);
            MS_P1:   pp_sh = PW'(pp) << HW;
            MS_P2:   pp_sh = PW'(pp) << HW;
            MS_P3:   pp_sh = PW'(pp) << WORD_W;
            default: pp_sh = '0;
        endcase
    end

    // Scale, saturate and subtract the finished product from the accumulator.
    always_comb begin
        p_ovf   = |r_prod[PW-1:WORD_W+FRAC_BITS];
        p_m     = r_prod[WORD_W+FRAC_BITS-1:FRAC_BITS];
        mul_sat = 1'b0;
        if (r_mneg) begin
            if (p_ovf || (p_m > W_MAG)) begin
                p_val   = W_MIN;
                mul_sat = 1'b1;
            end else begin
                p_val = ~p_m + 1'b1;
            end
        end else begin
            if (p_ovf || p_m[WORD_W-1]) begin
                p_val   = W_MAX;
                mul_sat = 1'b1;
            end else begin
                p_val = p_m;
            end
        end
        diff = {r_s[WORD_W-1], r_s} - {p_val[WORD_W-1], p_val};
        if (diff[WORD_W] != diff[WORD_W-1]) begin
            mul_res = diff[WORD_W] ? W_MIN : W_MAX;
            mul_sat = 1'b1;
        end else begin
            mul_res = diff[WORD_W-1:0];
        end
    end

    // Divider step and final saturation of the quotient to the word range.
    always_comb begin
        md_new  = mag(i_mat_rdata);
        md_zero = (md_new == '0);
        rem2    = {r_rem, r_dnum[NW-1]};
        rem_ge  = (rem2 >= {1'b0, r_md});
        div_fin = r_dbusy && (r_dcnt == '0);
        div_sat = 1'b0;
        if (r_dneg) begin
            if (r_q > Q_MAG) begin
                div_res = W_MIN;
                div_sat = 1'b1;
            end else begin
                div_res = ~r_q[WORD_W-1:0] + 1'b1;
            end
        end else begin
            if (r_q >= Q_MAG) begin
                div_res = W_MAX;
                div_sat = 1'b1;
            end else begin
                div_res = r_q[WORD_W-1:0];
            end
        end
    end

    always_comb begin
        s_out32 = !((&r_s[WORD_W-1:VAL_W-1]) || !(|r_s[WORD_W-1:VAL_W-1]));
        v_out32 = !((&i_vec_rdata[WORD_W-1:VAL_W-1]) ||
                    !(|i_vec_rdata[WORD_W-1:VAL_W-1]));
        if (v_out32) begin
            v_clamp = i_vec_rdata[WORD_W-1] ? {1'b1, {(VAL_W-1){1'b0}}}
                                            : {1'b0, {(VAL_W-1){1'b1}}};
        end else begin
            v_clamp = i_vec_rdata[VAL_W-1:0];
        end
        sing_set = i_cmd.div_start && md_zero;
        sat_set  = ((r_mstep == MS_FIN) && mul_sat) || (div_fin && div_sat) ||
                   (i_cmd.chk32 && s_out32);
    end

    always_comb begin
        case (i_cmd.wsel)
            WSEL_LOAD: o_wdata = {{(WORD_W-VAL_W){i_value[VAL_W-1]}}, i_value};
            WSEL_S:    o_wdata = r_s;
            default:   o_wdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mstep  <= MS_IDLE;
            r_dbusy  <= 1'b0;
            r_dcnt   <= '0;
            r_sing   <= 1'b0;
            r_sat    <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.emit;
            if (i_cmd.clr_flags) begin
                r_sing <= 1'b0;
                r_sat  <= 1'b0;
            end else begin
                r_sing <= r_sing | sing_set;
                r_sat  <= r_sat | sat_set;
            end
            case (r_mstep)
                MS_IDLE: r_mstep <= i_cmd.mul_start ? MS_P0 : MS_IDLE;
                MS_P0:   r_mstep <= MS_P1;
                MS_P1:   r_mstep <= MS_P2;
                MS_P2:   r_mstep <= MS_P3;
                MS_P3:   r_mstep <= MS_FIN;
                default: r_mstep <= MS_IDLE;
            endcase
            if (i_cmd.div_start && !md_zero) begin
                r_dbusy <= 1'b1;
                r_dcnt  <= DCW'(NW);
            end else if (r_dbusy) begin
                if (r_dcnt != '0) begin
                    r_dcnt <= r_dcnt - 1'b1;
                end else begin
                    r_dbusy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_s) begin
            r_s <= rd_sel;
        end else if (r_mstep == MS_FIN) begin
            r_s <= mul_res;
        end else if (sing_set) begin
            r_s <= '0;
        end else if (div_fin) begin
            r_s <= div_res;
        end
        if (i_cmd.ld_a) begin
            r_a <= i_mat_rdata;
        end
        if (i_cmd.mul_start) begin
            r_ma   <= mag(r_a);
            r_mb   <= mag(rd_sel);
            r_mneg <= r_a[WORD_W-1] ^ rd_sel[WORD_W-1];
            r_prod <= '0;
        end else if ((r_mstep != MS_IDLE) && (r_mstep != MS_FIN)) begin
            r_prod <= r_prod + pp_sh;
        end
        if (i_cmd.div_start) begin
            r_dnum <= {mag(r_s), {FRAC_BITS{1'b0}}};
            r_rem  <= '0;
            r_q    <= '0;
            r_md   <= md_new;
            r_dneg <= r_s[WORD_W-1] ^ i_mat_rdata[WORD_W-1];
        end else if (r_dbusy && (r_dcnt != '0)) begin
            r_rem  <= rem_ge ? WORD_W'(rem2 - {1'b0, r_md}) : rem2[WORD_W-1:0];
            r_q    <= {r_q[NW-2:0], rem_ge};
            r_dnum <= {r_dnum[NW-2:0], 1'b0};
        end
        if (i_cmd.emit) begin
            r_res.index       <= i_cmd.emit_idx;
            r_res.solution    <= v_clamp;
            r_res.singular    <= r_sing;
            r_res.saturated   <= r_sat;
            r_res.last_result <= i_cmd.emit_last;
        end
    end

    assign o_sts.mul_busy = (r_mstep != MS_IDLE);
    assign o_sts.div_busy = r_dbusy;
    assign o_strobe       = r_strobe;
    assign o_result       = r_res;
endmodule

[rtl/core/dlu_ctrl.sv]
// ============================================================================
// dlu_ctrl
// Sequencer of the LU solver: loading, factorisation, both substitutions,
// result emission and the clearing sweep of the stores.
// ============================================================================
module dlu_ctrl #(
    parameter int MAX_ORDER = dlu_pkg::MAX_ORDER_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    output logic                                   o_busy,
    input  dlu_pkg::t_item                         i_item,
    input  logic                                   i_cfg_we,
    input  logic [dlu_pkg::ORD_W-1:0]              i_cfg_wdata,
    output dlu_pkg::t_cmd                          o_cmd,
    input  dlu_pkg::t_sts                          i_sts,
    output logic                                   o_mat_we,
    output logic [$clog2(MAX_ORDER*MAX_ORDER)-1:0] o_mat_waddr,
    output logic [$clog2(MAX_ORDER*MAX_ORDER)-1:0] o_mat_raddr,
    output logic                                   o_vec_we,
    output logic [$clog2(MAX_ORDER)-1:0]           o_vec_waddr,
    output logic [$clog2(MAX_ORDER)-1:0]           o_vec_raddr
);
    import dlu_pkg::*;

    localparam int MD   = MAX_ORDER * MAX_ORDER;
    localparam int MAW  = $clog2(MD);
    localparam int VAW  = $clog2(MAX_ORDER);
    localparam int CW   = $clog2(MAX_ORDER + 1);
    localparam int NLIM = (MAX_ORDER < 16) ? MAX_ORDER : 16;

    localparam logic [3:0] ST_CLEAR = 4'd0;
    localparam logic [3:0] ST_IDLE  = 4'd1;
    localparam logic [3:0] ST_RS    = 4'd2;
    localparam logic [3:0] ST_LS    = 4'd3;
    localparam logic [3:0] ST_JCHK  = 4'd4;
    localparam logic [3:0] ST_LA    = 4'd5;
    localparam logic [3:0] ST_LB    = 4'd6;
    localparam logic [3:0] ST_MW    = 4'd7;
    localparam logic [3:0] ST_LD    = 4'd8;
    localparam logic [3:0] ST_DW    = 4'd9;
    localparam logic [3:0] ST_WR    = 4'd10;
    localparam logic [3:0] ST_ER    = 4'd11;
    localparam logic [3:0] ST_EO    = 4'd12;

    localparam logic [1:0] PH_U = 2'd0;
    localparam logic [1:0] PH_L = 2'd1;
    localparam logic [1:0] PH_F = 2'd2;
    localparam logic [1:0] PH_B = 2'd3;

    function automatic logic [MAW-1:0] maddr(input logic [CW-1:0] r,
                                             input logic [CW-1:0] c);
        return MAW'(32'(r) * MAX_ORDER + 32'(c));
    endfunction

    logic [3:0]       r_state, n_state;
    logic [1:0]       r_phase, n_phase;
    logic [CW-1:0]    r_i, n_i, r_k, n_k, r_j, n_j;
    logic [MAW-1:0]   r_clr, n_clr;
    logic [ORD_W-1:0] r_order;

    logic [CW-1:0]  n_eff, jend, jstart;
    logic           vec_ph, div_ph, row_ok, col_ok;
    logic [MAW-1:0] s_addr, a_addr, b_addr, d_addr;

    always_comb begin
        if (r_order == '0) begin
            n_eff = CW'(1);
        end else if (32'(r_order) > NLIM) begin
            n_eff = CW'(NLIM);
        end else begin
            n_eff = CW'(r_order);
        end
        vec_ph = (r_phase == PH_F) || (r_phase == PH_B);
        div_ph = (r_phase == PH_L) || (r_phase == PH_B);
        jend   = (r_phase == PH_B) ? n_eff : r_i;
        jstart = (r_phase == PH_B) ? (r_i + 1'b1) : '0;
        s_addr = (r_phase == PH_L) ? maddr(r_k, r_i) : maddr(r_i, r_k);
        a_addr = (r_phase == PH_L) ? maddr(r_k, r_j) : maddr(r_i, r_j);
        b_addr = (r_phase == PH_L) ? maddr(r_j, r_i) : maddr(r_j, r_k);
        d_addr = maddr(r_i, r_i);
        row_ok = 32'(i_item.row) < MAX_ORDER;
        col_ok = 32'(i_item.col) < MAX_ORDER;
    end

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_i         = r_i;
        n_k         = r_k;
        n_j         = r_j;
        n_clr       = r_clr;
        o_cmd       = '0;
        o_mat_we    = 1'b0;
        o_mat_waddr = '0;
        o_mat_raddr = '0;
        o_vec_we    = 1'b0;
        o_vec_waddr = '0;
        o_vec_raddr = '0;
        case (r_state)
            ST_CLEAR: begin
                o_mat_we        = 1'b1;
                o_mat_waddr     = r_clr;
                o_vec_we        = 32'(r_clr) < MAX_ORDER;
                o_vec_waddr     = VAW'(r_clr);
                o_cmd.wsel      = WSEL_ZERO;
                o_cmd.clr_flags = 1'b1;
                if (r_clr == MAW'(MD - 1)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end
            ST_IDLE: begin
                if (i_start) begin
                    o_cmd.wsel = WSEL_LOAD;
                    if (i_item.kind == KIND_MAT) begin
                        o_mat_we    = row_ok && col_ok;
                        o_mat_waddr = MAW'(32'(i_item.row) * MAX_ORDER +
                                           32'(i_item.col));
                    end else begin
                        o_vec_we    = row_ok;
                        o_vec_waddr = VAW'(i_item.row);
                    end
                    if (i_item.last_item) begin
                        n_state = ST_RS;
                        n_phase = PH_U;
                        n_i     = '0;
                        n_k     = '0;
                    end
                end
            end
            ST_RS: begin
                if (vec_ph) begin
                    o_vec_raddr = VAW'(r_i);
                end else begin
                    o_mat_raddr = s_addr;
                end
                n_j     = jstart;
                n_state = ST_LS;
            end
            ST_LS: begin
                o_cmd.ld_s    = 1'b1;
                o_cmd.sel_vec = vec_ph;
                n_state       = ST_JCHK;
            end
            ST_JCHK: begin
                if (r_j < jend) begin
                    o_mat_raddr = a_addr;
                    n_state     = ST_LA;
                end else if (div_ph) begin
                    o_mat_raddr = d_addr;
                    n_state     = ST_LD;
                end else begin
                    n_state = ST_WR;
                end
            end
            ST_LA: begin
                o_cmd.ld_a = 1'b1;
                if (vec_ph) begin
                    o_vec_raddr = VAW'(r_j);
                end else begin
                    o_mat_raddr = b_addr;
                end
                n_state = ST_LB;
            end
            ST_LB: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.sel_vec   = vec_ph;
                n_state         = ST_MW;
            end
            ST_MW: begin
                if (!i_sts.mul_busy) begin
                    n_j     = r_j + 1'b1;
                    n_state = ST_JCHK;
                end
            end
            ST_LD: begin
                o_cmd.div_start = 1'b1;
                n_state         = ST_DW;
            end
            ST_DW: begin
                if (!i_sts.div_busy) begin
                    n_state = ST_WR;
                end
            end
            ST_WR: begin
                o_cmd.wsel = WSEL_S;
                n_state    = ST_RS;
                if (vec_ph) begin
                    o_vec_we    = 1'b1;
                    o_vec_waddr = VAW'(r_i);
                    o_cmd.chk32 = (r_phase == PH_B);
                end else begin
                    o_mat_we    = 1'b1;
                    o_mat_waddr = s_addr;
                end
                case (r_phase)
                    PH_U: begin
                        if ((r_k + 1'b1) < n_eff) begin
                            n_k = r_k + 1'b1;
                        end else if ((r_i + 1'b1) < n_eff) begin
                            n_phase = PH_L;
                            n_k     = r_i + 1'b1;
                        end else begin
                            n_phase = PH_F;
                            n_i     = '0;
                        end
                    end
                    PH_L: begin
                        if ((r_k + 1'b1) < n_eff) begin
                            n_k = r_k + 1'b1;
                        end else begin
                            n_phase = PH_U;
                            n_i     = r_i + 1'b1;
                            n_k     = r_i + 1'b1;
                        end
                    end
                    PH_F: begin
                        if ((r_i + 1'b1) < n_eff) begin
                            n_i = r_i + 1'b1;
                        end else begin
                            n_phase = PH_B;
                            n_i     = n_eff - 1'b1;
                        end
                    end
                    default: begin
                        if (r_i == '0) begin
                            n_state = ST_ER;
                        end else begin
                            n_i = r_i - 1'b1;
                        end
                    end
                endcase
            end
            ST_ER: begin
                o_vec_raddr = VAW'(r_i);
                n_state     = ST_EO;
            end
            ST_EO: begin
                o_cmd.emit      = 1'b1;
                o_cmd.emit_idx  = IDX_W'(r_i);
                o_cmd.emit_last = ((r_i + 1'b1) == n_eff);
                if ((r_i + 1'b1) == n_eff) begin
                    n_state = ST_CLEAR;
                    n_clr   = '0;
                end else begin
                    n_i     = r_i + 1'b1;
                    n_state = ST_ER;
                end
            end
            default: begin
                n_state = ST_CLEAR;
                n_clr   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_phase <= PH_U;
            r_i     <= '0;
            r_k     <= '0;
            r_j     <= '0;
            r_clr   <= '0;
            r_order <= ORD_RESET;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
            r_i     <= n_i;
            r_k     <= n_k;
            r_j     <= n_j;
            r_clr   <= n_clr;
            if (i_cfg_we) begin
                r_order <= i_cfg_wdata;
            end
        end
    end

    assign o_busy = (r_state != ST_IDLE);

`ifndef NO_ASSERTIONS
    a_emit_units_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EO) |-> (!i_sts.mul_busy && !i_sts.div_busy))
        else $error("result emitted while an arithmetic unit is busy");

    a_j_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_JCHK) |-> (r_j <= jend))
        else $error("inner index ran past its bound");

    a_clear_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR && r_clr == MAW'(MD - 1)) |=> (r_state == ST_IDLE))
        else $error("clearing sweep did not return to idle");
`endif
endmodule
